// ===== hw/rtl/nmea_sentence_checksum_checker_core_defines.svh =====
// ----------------------------------------------------------------------------
// NMEA checksum checker assertion macros
// Shared assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef NMEA_SENTENCE_CHECKSUM_CHECKER_CORE_DEFINES_SVH
`define NMEA_SENTENCE_CHECKSUM_CHECKER_CORE_DEFINES_SVH

// Same-cycle implication, masked while in reset
`define NSC_CHK_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nsc port check failed");

// Next-cycle implication, masked while in reset
`define NSC_CHK_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nsc port check failed");

// Next-cycle implication, checked during reset too
`define NSC_CHK_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("nsc port check failed");

`endif

// ===== hw/rtl/nsc_pkg.sv =====
// ----------------------------------------------------------------------------
// NMEA checksum checker package
// Item, result and state types used by the front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none

package nsc_pkg;

  // Character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DIG_LO = 8'h30;
  localparam logic [7:0] CH_DIG_HI = 8'h39;
  localparam logic [7:0] CH_LET_LO = 8'h41;
  localparam logic [7:0] CH_LET_HI = 8'h5A;

  localparam logic [23:0] TYPE_RESET = 24'h524D43;

  // Queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  // Result status codes
  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_NO_STAR  = 2'd1;
  localparam logic [1:0] ST_BAD_DIG  = 2'd2;
  localparam logic [1:0] ST_MISMATCH = 2'd3;

  typedef enum logic [2:0] {
    KIND_DOLLAR,
    KIND_CR,
    KIND_LF,
    KIND_STAR,
    KIND_OTHER
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BODY,
    PH_DIG1,
    PH_DIG2,
    PH_AFTER
  } phase_t;

  // Classified character
  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       dig_ok;
    logic [5:0] dig_val;
  } item_t;

  // Result, first field in the high bits
  typedef struct packed {
    logic [6:0] body_length;
    logic [9:0] received_sum;
    logic [7:0] computed_sum;
    logic [1:0] status;
  } result_t;

  // Queue status seen by the producer and consumer
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nsc_front.sv =====
// ----------------------------------------------------------------------------
// NMEA checksum checker front
// Accepts received bytes and classifies them for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module nsc_front (
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [7:0]     in_tdata,   // [7:0] rx_byte
  input  wire nsc_pkg::q_stat_t q_stat,
  output logic                push,
  output nsc_pkg::item_t      push_item
);

  // Accept while the queue has room
  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && !q_stat.full;

  // Classify the byte and decode a check digit
  always_comb begin
    push_item.ch      = in_tdata;
    push_item.dig_ok  = 1'b0;
    push_item.dig_val = 6'd0;
    priority if (in_tdata == nsc_pkg::CH_DOLLAR) push_item.kind = nsc_pkg::KIND_DOLLAR;
    else if (in_tdata == nsc_pkg::CH_CR)         push_item.kind = nsc_pkg::KIND_CR;
    else if (in_tdata == nsc_pkg::CH_LF)         push_item.kind = nsc_pkg::KIND_LF;
    else if (in_tdata == nsc_pkg::CH_STAR)       push_item.kind = nsc_pkg::KIND_STAR;
    else                                         push_item.kind = nsc_pkg::KIND_OTHER;
    if (in_tdata >= nsc_pkg::CH_DIG_LO && in_tdata <= nsc_pkg::CH_DIG_HI) begin
      push_item.dig_ok  = 1'b1;
      push_item.dig_val = 6'(in_tdata - nsc_pkg::CH_DIG_LO);
    end else if (in_tdata >= nsc_pkg::CH_LET_LO && in_tdata <= nsc_pkg::CH_LET_HI) begin
      push_item.dig_ok  = 1'b1;
      push_item.dig_val = 6'(in_tdata - nsc_pkg::CH_LET_LO) + 6'd10;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nsc_fifo.sv =====
// ----------------------------------------------------------------------------
// NMEA checksum checker queue
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module nsc_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire nsc_pkg::item_t push_item,
  input  wire logic           pop,
  output nsc_pkg::item_t      head,
  output nsc_pkg::q_stat_t    q_stat
);

  nsc_pkg::item_t                mem [nsc_pkg::Q_DEPTH];
  logic [nsc_pkg::Q_AW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [nsc_pkg::Q_AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [nsc_pkg::Q_AW:0]        count_r, count_nxt;

  assign q_stat.full  = (count_r == (nsc_pkg::Q_AW+1)'(nsc_pkg::Q_DEPTH));
  assign q_stat.valid = (count_r != '0);
  assign head         = mem[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (nsc_pkg::Q_AW+1)'(push) - (nsc_pkg::Q_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nsc_back.sv =====
// ----------------------------------------------------------------------------
// NMEA checksum checker back
// Runs the sentence parser on queued items and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module nsc_back #(
  parameter int LINE_LIMIT = 128
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [23:0]       sentence_type,
  input  wire nsc_pkg::q_stat_t  q_stat,
  input  wire nsc_pkg::item_t    head,
  output logic                   pop,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output nsc_pkg::result_t       out_result
);

  localparam int CNT_W = $clog2(LINE_LIMIT);
  localparam int WID_W = CNT_W + 8;
  localparam logic [CNT_W-1:0] KEEP_LEN = CNT_W'(LINE_LIMIT - 1);

  nsc_pkg::phase_t   phase_r, phase_nxt;
  logic              cr_r, cr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [7:0]        xor_r, xor_nxt;
  logic [23:0]       shift_r, shift_nxt;
  logic              match_r, match_nxt;
  logic [9:0]        dig_r, dig_nxt;
  logic              err_r, err_nxt;
  logic [6:0]        blen_r, blen_nxt;
  logic              ovalid_r, ovalid_nxt;
  nsc_pkg::result_t  res_r, res_nxt;
  logic [WID_W-1:0]  count_wide;
  logic [6:0]        count_sat;
  logic              emit;

  // Hold only an item that would emit while the result slot is still taken
  assign emit       = (head.kind == nsc_pkg::KIND_LF) && cr_r && match_r &&
                      (phase_r != nsc_pkg::PH_IDLE);
  assign pop        = q_stat.valid && (!emit || !ovalid_r || out_tready);
  assign out_tvalid = ovalid_r;
  assign out_result = res_r;

  // Saturate the position to the 7-bit length field
  assign count_wide = WID_W'(count_r);
  assign count_sat  = (count_wide > WID_W'(127)) ? 7'd127 : count_wide[6:0];

  // Parser next state and result
  always_comb begin
    phase_nxt  = phase_r;
    cr_nxt     = cr_r;
    count_nxt  = count_r;
    xor_nxt    = xor_r;
    shift_nxt  = shift_r;
    match_nxt  = match_r;
    dig_nxt    = dig_r;
    err_nxt    = err_r;
    blen_nxt   = blen_r;
    res_nxt    = res_r;
    ovalid_nxt = (ovalid_r && !out_tready);
    if (pop) begin
      priority if (head.kind == nsc_pkg::KIND_DOLLAR) begin
        // Start a new sentence, dropping any open one
        phase_nxt = nsc_pkg::PH_BODY;
        cr_nxt    = 1'b0;
        count_nxt = '0;
        xor_nxt   = '0;
        shift_nxt = '0;
        match_nxt = 1'b0;
        dig_nxt   = '0;
        err_nxt   = 1'b0;
        blen_nxt  = '0;
      end else if (phase_r == nsc_pkg::PH_IDLE) begin
        cr_nxt = 1'b0;
      end else if (head.kind == nsc_pkg::KIND_LF && cr_r) begin
        // End of line: report a sentence of the selected type
        if (match_r) begin
          ovalid_nxt           = 1'b1;
          res_nxt.computed_sum = xor_r;
          res_nxt.received_sum = dig_r;
          if (phase_r == nsc_pkg::PH_BODY) begin
            res_nxt.status      = nsc_pkg::ST_NO_STAR;
            res_nxt.body_length = count_sat;
          end else if (phase_r == nsc_pkg::PH_DIG1 || phase_r == nsc_pkg::PH_DIG2 ||
                       err_r) begin
            res_nxt.status      = nsc_pkg::ST_BAD_DIG;
            res_nxt.body_length = blen_r;
          end else begin
            res_nxt.status      = (dig_r == {2'b00, xor_r}) ? nsc_pkg::ST_GOOD
                                                            : nsc_pkg::ST_MISMATCH;
            res_nxt.body_length = blen_r;
          end
        end
        phase_nxt = nsc_pkg::PH_IDLE;
        cr_nxt    = 1'b0;
        count_nxt = '0;
        xor_nxt   = '0;
        shift_nxt = '0;
        match_nxt = 1'b0;
        dig_nxt   = '0;
        err_nxt   = 1'b0;
        blen_nxt  = '0;
      end else if (head.kind == nsc_pkg::KIND_CR) begin
        cr_nxt = 1'b1;
      end else begin
        cr_nxt = 1'b0;
        if (count_r < KEEP_LEN) begin
          count_nxt = count_r + 1'b1;
          unique case (phase_r)
            nsc_pkg::PH_BODY: begin
              if (head.kind == nsc_pkg::KIND_STAR) begin
                blen_nxt  = count_sat;
                phase_nxt = nsc_pkg::PH_DIG1;
              end else begin
                xor_nxt = xor_r ^ head.ch;
                if (count_r == CNT_W'(2) || count_r == CNT_W'(3) ||
                    count_r == CNT_W'(4)) begin
                  shift_nxt = {shift_r[15:0], head.ch};
                end
                if (count_r == CNT_W'(4)) begin
                  match_nxt = ({shift_r[15:0], head.ch} == sentence_type);
                end
              end
            end
            nsc_pkg::PH_DIG1: begin
              if (!head.dig_ok) begin
                err_nxt   = 1'b1;
                phase_nxt = nsc_pkg::PH_AFTER;
              end else begin
                dig_nxt   = {head.dig_val, 4'b0000};
                phase_nxt = nsc_pkg::PH_DIG2;
              end
            end
            nsc_pkg::PH_DIG2: begin
              if (!head.dig_ok) begin
                err_nxt = 1'b1;
              end else begin
                dig_nxt = dig_r + {4'b0000, head.dig_val};
              end
              phase_nxt = nsc_pkg::PH_AFTER;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= nsc_pkg::PH_IDLE;
      cr_r     <= 1'b0;
      count_r  <= '0;
      xor_r    <= '0;
      shift_r  <= '0;
      match_r  <= 1'b0;
      dig_r    <= '0;
      err_r    <= 1'b0;
      blen_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      cr_r     <= cr_nxt;
      count_r  <= count_nxt;
      xor_r    <= xor_nxt;
      shift_r  <= shift_nxt;
      match_r  <= match_nxt;
      dig_r    <= dig_nxt;
      err_r    <= err_nxt;
      blen_r   <= blen_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nmea_sentence_checksum_checker_core.sv =====
// ----------------------------------------------------------------------------
// NMEA 0183 sentence checksum checker.
// Input stream (in_*): one received character per item. A '$' opens a
// sentence; talker, type and fields are XORed up to the '*', the type at
// header positions three to five is compared with the configured type, and
// two check digits (0-9, A-Z) follow the '*'.
// Result stream (out_*): one item per CR LF that closes a sentence of the
// configured type, carrying status, computed sum, received sum and length.
// Configuration: cfg_wr_en writes the 24-bit sentence type; write only when
// the block is idle. Reset value is "RMC".
// Throughput: one character per cycle while the queue has room. With an empty
// queue the LF is written to the queue when accepted, and the parser and result
// register then take it, after which the result is offered.
// Reset (rst_n low, synchronous) empties the queue, drops any open sentence
// and empties the result slot.
// When out_tready is low the result is held and characters keep flowing;
// only the LF that closes a further matching sentence waits in the
// four-entry queue, which then fills until in_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_checksum_checker_core #(
  parameter int LINE_LIMIT = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [23:0] cfg_wr_data,  // [23:0] sentence_type
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata     // [1:0] status, [9:2] computed_sum,
                                         // [19:10] received_sum, [26:20] body_length
);

  logic [23:0]       type_r;
  logic              push;
  logic              pop;
  nsc_pkg::item_t    push_item;
  nsc_pkg::item_t    head;
  nsc_pkg::q_stat_t  q_stat;
  nsc_pkg::result_t  result;

  // Hold the configured sentence type
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r <= nsc_pkg::TYPE_RESET;
    end else if (cfg_wr_en) begin
      type_r <= cfg_wr_data;
    end
  end

  nsc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  nsc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  nsc_back #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .sentence_type (type_r),
    .q_stat        (q_stat),
    .head          (head),
    .pop           (pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_result    (result)
  );

  assign out_tdata = {5'b00000, result};

endmodule

`default_nettype wire

// ===== hw/rtl/nsc_checker.sv =====
// ----------------------------------------------------------------------------
// NMEA checksum checker port checker
// Watches the top-level ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
`default_nettype none

`include "nmea_sentence_checksum_checker_core_defines.svh"

module nsc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata
);

  logic       res_nostar;
  logic       res_good;
  logic [9:0] res_recv;
  logic [9:0] res_comp;

  // Decode the offered result
  assign res_nostar = out_tvalid && (out_tdata[1:0] == nsc_pkg::ST_NO_STAR);
  assign res_good   = out_tvalid && (out_tdata[1:0] == nsc_pkg::ST_GOOD);
  assign res_recv   = out_tdata[19:10];
  assign res_comp   = {2'b00, out_tdata[9:2]};

  // Result slot is empty right after reset
  `NSC_CHK_NEXT_ALWAYS(a_rst_empty, clk, !rst_n, !out_tvalid)

  // Stalled result stays offered and unchanged
  `NSC_CHK_NEXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `NSC_CHK_NEXT(a_stall_data, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))

  // No asterisk means no check digits were read
  `NSC_CHK_NOW(a_nostar_sum, clk, rst_n, res_nostar, res_recv == 10'd0)

  // Good status means the sums agree
  `NSC_CHK_NOW(a_good_sum, clk, rst_n, res_good, res_recv == res_comp)

endmodule

bind nmea_sentence_checksum_checker_core nsc_checker u_nsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
